FILE: sv/alp_pkg.sv
// Package: constants and result beat type for the ALP response parser.
package alp_pkg;

    localparam int MAX_SLOTS = 8;

    localparam logic [7:0] OPCODE_MASK  = 8'h3F;
    localparam logic [5:0] OP_FILE_DATA = 6'h20;
    localparam logic [5:0] OP_STATUS    = 6'h22;
    localparam logic [5:0] OP_TAG       = 6'h23;

    localparam logic [7:0] STATUS_BYTES    = 8'd22;
    localparam logic [7:0] STATUS_RSSI_POS = 8'd5;
    localparam logic [7:0] STATUS_UID_POS  = 8'd14;

    localparam logic [3:0] MAX_FILES_RESET = 4'd8;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Output queue: one byte can give two beats, so depth leaves room for
    // the byte in the input register plus the byte being accepted.
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  slot;
        logic [7:0]  file_id;
        logic [7:0]  file_offset;
        logic [7:0]  file_length;
        logic [7:0]  data_value;
        logic [7:0]  byte_index;
        logic [3:0]  file_count;
        logic [63:0] uid;
        logic [7:0]  rssi;
        logic        uid_valid;
        logic        last_of_run;
    } result_t;

endpackage

FILE: sv/alp_response_parser.sv
// Top level: ALP response message parser, one message byte per cycle while in_stall is low.
//
//   channel | direction | handshake         | beat contents
//   --------+-----------+-------------------+----------------------------------
//   in      | input     | in_valid/in_stall | data_byte, last_byte
//   out     | output    | out_valid/out_stall| kind, slot, file_*, data_value,
//           |           |                   | byte_index, file_count, uid, rssi,
//           |           |                   | uid_valid, last_of_run
//   cfg     | input     | cfg_valid/cfg_ready| cfg_data -> max_files
//
// One byte is accepted per cycle while in_stall is low. An accepted byte is held
// in the input register, is parsed against the state registers and its beats
// (zero, one or two) are written into an 8-entry output queue at the next edge;
// the first beat is on the output right after that edge if the queue was empty.
// The queue sets the stall: in_stall rises when the queue could not hold two
// more beats for both the registered byte and a new one.
// rst_n clears parser state, the queue and sets max_files to 8. cfg_ready is
// always high.
module alp_response_parser (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [2:0]  slot,
    output logic [7:0]  file_id,
    output logic [7:0]  file_offset,
    output logic [7:0]  file_length,
    output logic [7:0]  data_value,
    output logic [7:0]  byte_index,
    output logic [3:0]  file_count,
    output logic [63:0] uid,
    output logic [7:0]  rssi,
    output logic        uid_valid,
    output logic        last_of_run
);
    import alp_pkg::*;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_FILE_ID,
        PH_OFFSET,
        PH_LENGTH,
        PH_DATA,
        PH_STATUS,
        PH_TAG,
        PH_SKIP
    } phase_t;

    // Config register
    logic [3:0] max_files_reg;

    // Input register
    logic       stage_valid_reg;
    logic [7:0] stage_byte_reg;
    logic       stage_last_reg;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  field_cnt_reg, field_cnt_next;
    logic [7:0]  file_id_reg, file_id_next;
    logic [7:0]  offset_reg, offset_next;
    logic [7:0]  length_reg, length_next;
    logic        taken_reg, taken_next;
    logic [3:0]  saved_reg, saved_next;
    logic [7:0]  rssi_reg, rssi_next;
    logic [63:0] uid_reg, uid_next;

    // Output queue
    result_t           fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    result_t    res0, res1, file_res, sum_res;
    logic       emit_file;
    logic [1:0] n_push;
    logic       pop;
    logic       in_accept;

    logic [3:0] limit;
    logic [7:0] keep;
    logic [7:0] cnt_inc;
    logic [CNT_W:0] room_need;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && !in_stall;

    // Worst case after the next edge: registered byte adds two, new byte two.
    assign room_need = {1'b0, count_reg} + (stage_valid_reg ? (CNT_W+1)'(2) : '0);
    assign in_stall  = room_need > (CNT_W+1)'(FIFO_DEPTH - 2);

    assign out_valid = count_reg != '0;
    assign pop       = out_valid && !out_stall;

    assign limit   = (max_files_reg < 4'(MAX_SLOTS)) ? max_files_reg : 4'(MAX_SLOTS);
    assign keep    = (length_reg > offset_reg) ? (length_reg - offset_reg) : 8'd0;
    assign cnt_inc = field_cnt_reg + 8'd1;

    // Parse one byte
    always_comb
    begin
        phase_next     = phase_reg;
        field_cnt_next = field_cnt_reg;
        file_id_next   = file_id_reg;
        offset_next    = offset_reg;
        length_next    = length_reg;
        taken_next     = taken_reg;
        saved_next     = saved_reg;
        rssi_next      = rssi_reg;
        uid_next       = uid_reg;
        emit_file      = 1'b0;
        file_res       = '0;

        unique case (phase_reg)
            PH_OPCODE:
            begin
                unique case (stage_byte_reg[5:0] & OPCODE_MASK[5:0])
                    OP_FILE_DATA: phase_next = PH_FILE_ID;
                    OP_STATUS:
                    begin
                        phase_next     = PH_STATUS;
                        field_cnt_next = 8'd0;
                    end
                    OP_TAG:       phase_next = PH_TAG;
                    default:      phase_next = PH_SKIP;
                endcase
            end
            PH_FILE_ID:
            begin
                file_id_next = stage_byte_reg;
                phase_next   = PH_OFFSET;
            end
            PH_OFFSET:
            begin
                offset_next = stage_byte_reg;
                phase_next  = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                length_next = stage_byte_reg;
                if (saved_reg < limit)
                begin
                    taken_next = 1'b1;
                    saved_next = saved_reg + 4'd1;
                    emit_file  = 1'b1;
                    file_res.kind        = KIND_HEADER;
                    file_res.slot        = saved_reg[2:0];
                    file_res.file_id     = file_id_reg;
                    file_res.file_offset = offset_reg;
                    file_res.file_length = stage_byte_reg;
                    file_res.file_count  = saved_reg + 4'd1;
                end
                else
                begin
                    taken_next = 1'b0;
                end
                field_cnt_next = 8'd0;
                phase_next     = (stage_byte_reg == 8'd0) ? PH_OPCODE : PH_DATA;
            end
            PH_DATA:
            begin
                if (taken_reg && field_cnt_reg < keep)
                begin
                    emit_file = 1'b1;
                    file_res.kind        = KIND_DATA;
                    file_res.slot        = 3'(saved_reg - 4'd1);
                    file_res.file_id     = file_id_reg;
                    file_res.file_offset = offset_reg;
                    file_res.file_length = length_reg;
                    file_res.data_value  = stage_byte_reg;
                    file_res.byte_index  = field_cnt_reg;
                    file_res.file_count  = saved_reg;
                end
                field_cnt_next = cnt_inc;
                if (cnt_inc >= length_reg)
                begin
                    phase_next = PH_OPCODE;
                end
            end
            PH_STATUS:
            begin
                if (field_cnt_reg == STATUS_RSSI_POS)
                begin
                    rssi_next = stage_byte_reg;
                end
                if (field_cnt_reg >= STATUS_UID_POS)
                begin
                    uid_next = {uid_reg[55:0], stage_byte_reg};
                end
                field_cnt_next = cnt_inc;
                if (cnt_inc >= STATUS_BYTES)
                begin
                    phase_next = PH_OPCODE;
                end
            end
            PH_TAG:  phase_next = PH_OPCODE;
            PH_SKIP: phase_next = PH_SKIP;
            default: phase_next = PH_SKIP;
        endcase

        // Summary sees the state left by this byte
        sum_res            = '0;
        sum_res.kind       = KIND_SUMMARY;
        sum_res.file_count = saved_next;
        sum_res.uid        = uid_next;
        sum_res.rssi       = rssi_next;
        sum_res.uid_valid  = (uid_next != 64'd0) && (saved_next != 4'd0);

        if (stage_last_reg)
        begin
            phase_next     = PH_OPCODE;
            field_cnt_next = 8'd0;
            file_id_next   = 8'd0;
            offset_next    = 8'd0;
            length_next    = 8'd0;
            taken_next     = 1'b0;
            saved_next     = 4'd0;
            rssi_next      = 8'd0;
            uid_next       = 64'd0;
        end
    end

    // Pack beats for the queue; the final beat of the byte carries last_of_run
    always_comb
    begin
        res0   = '0;
        res1   = '0;
        n_push = 2'd0;
        if (stage_valid_reg)
        begin
            priority if (emit_file && stage_last_reg)
            begin
                res0   = file_res;
                res1   = sum_res;
                res1.last_of_run = 1'b1;
                n_push = 2'd2;
            end
            else if (emit_file)
            begin
                res0   = file_res;
                res0.last_of_run = 1'b1;
                n_push = 2'd1;
            end
            else if (stage_last_reg)
            begin
                res0   = sum_res;
                res0.last_of_run = 1'b1;
                n_push = 2'd1;
            end
            else
            begin
                n_push = 2'd0;
            end
        end
    end

    assign count_next = count_reg + CNT_W'(n_push) - (pop ? CNT_W'(1) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_files_reg   <= MAX_FILES_RESET;
            stage_valid_reg <= 1'b0;
            phase_reg       <= PH_OPCODE;
            field_cnt_reg   <= 8'd0;
            file_id_reg     <= 8'd0;
            offset_reg      <= 8'd0;
            length_reg      <= 8'd0;
            taken_reg       <= 1'b0;
            saved_reg       <= 4'd0;
            rssi_reg        <= 8'd0;
            uid_reg         <= 64'd0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_files_reg <= cfg_data;
            end
            stage_valid_reg <= in_accept;
            if (stage_valid_reg)
            begin
                phase_reg     <= phase_next;
                field_cnt_reg <= field_cnt_next;
                file_id_reg   <= file_id_next;
                offset_reg    <= offset_next;
                length_reg    <= length_next;
                taken_reg     <= taken_next;
                saved_reg     <= saved_next;
                rssi_reg      <= rssi_next;
                uid_reg       <= uid_next;
            end
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_push);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_byte_reg <= data_byte;
            stage_last_reg <= last_byte;
        end
        if (n_push != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (n_push == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    // Head of queue drives the output beat
    assign kind        = fifo_mem[rd_ptr_reg].kind;
    assign slot        = fifo_mem[rd_ptr_reg].slot;
    assign file_id     = fifo_mem[rd_ptr_reg].file_id;
    assign file_offset = fifo_mem[rd_ptr_reg].file_offset;
    assign file_length = fifo_mem[rd_ptr_reg].file_length;
    assign data_value  = fifo_mem[rd_ptr_reg].data_value;
    assign byte_index  = fifo_mem[rd_ptr_reg].byte_index;
    assign file_count  = fifo_mem[rd_ptr_reg].file_count;
    assign uid         = fifo_mem[rd_ptr_reg].uid;
    assign rssi        = fifo_mem[rd_ptr_reg].rssi;
    assign uid_valid   = fifo_mem[rd_ptr_reg].uid_valid;
    assign last_of_run = fifo_mem[rd_ptr_reg].last_of_run;

endmodule
